@@ rtl/core/fssa_pkg.sv @@
// Shared types and constants for the fixed-size slot allocator.
// Holds field widths, result status codes, register map and the
// controller/datapath command and status bundles. No dependencies.
package fssa_pkg;

  // Field widths of the item channels.
  localparam int ADDR_W   = 32;
  localparam int PAGE_W   = 20;
  localparam int STATUS_W = 3;
  localparam int CNT_W    = 9;

  // Configuration port and register map.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 2;
  localparam int SIZE_W     = 4;
  localparam logic [CFG_ADDR_W-1:0] ADDR_SLOT_SIZE_LOG2 = 2'd0;
  localparam logic [SIZE_W-1:0]     SIZE_LOG2_RESET     = 4'd4;
  localparam logic [4:0]            SIZE_LOG2_MIN       = 5'd4;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_EMPTY        = 3'd1,
    ST_MISALIGNED   = 3'd2,
    ST_NONE_ALLOC   = 3'd3,
    ST_NOT_FOUND    = 3'd4,
    ST_ALREADY_FREE = 3'd5
  } fssa_status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic clr_step;
    logic top_latch;
    logic chk_latch;
    logic walk_start;
    logic walk_step;
    logic commit_alloc;
    logic commit_free;
  } fssa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
    logic chk_fail;
    logic walk_done;
    logic walk_found;
    logic out_free;
  } fssa_sts_t;

endpackage

@@ rtl/core/fssa_if.sv @@
// Valid/ready channel interfaces for allocator requests and results.
// Depends on fssa_pkg for the field widths.
interface fssa_in_if
  import fssa_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              func;
  logic [ADDR_W-1:0] address;
  logic [PAGE_W-1:0] offered_page;

  modport source (output valid, func, address, offered_page, input ready);
  modport sink   (input valid, func, address, offered_page, output ready);
endinterface

interface fssa_out_if
  import fssa_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   slot_address;
  logic [STATUS_W-1:0] status;
  logic                page_taken;
  logic [CNT_W-1:0]    allocation_count;

  modport source (output valid, slot_address, status, page_taken, allocation_count,
                  input ready);
  modport sink   (input valid, slot_address, status, page_taken, allocation_count,
                  output ready);
endinterface

@@ rtl/core/fssa_ctrl.sv @@
// Sequencing state machine of the slot allocator.
// Depends on fssa_pkg for the command and status bundles.
module fssa_ctrl
  import fssa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_func,
  output logic      in_ready,
  input  fssa_sts_t sts,
  output fssa_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_A_TOP, S_A_PT, S_A_FIN, S_F_CHK, S_F_WALK, S_F_USE, S_F_FIN
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands for the current state.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = in_func ? S_F_CHK : S_A_TOP;
        end
      end
      S_A_TOP: begin
        cmd.top_latch = 1'b1;
        state_nxt     = S_A_PT;
      end
      S_A_PT: state_nxt = S_A_FIN;
      S_A_FIN: begin
        if (sts.out_free) begin
          cmd.commit_alloc = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      S_F_CHK: begin
        cmd.chk_latch = 1'b1;
        if (sts.chk_fail) begin
          state_nxt = S_F_FIN;
        end else begin
          cmd.walk_start = 1'b1;
          state_nxt      = S_F_WALK;
        end
      end
      S_F_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_done) state_nxt = sts.walk_found ? S_F_USE : S_F_FIN;
      end
      S_F_USE: state_nxt = S_F_FIN;
      S_F_FIN: begin
        if (sts.out_free) begin
          cmd.commit_free = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/core/fssa_datapath.sv @@
// Datapath of the slot allocator: free stack, in-use bits, page table,
// counters, page-table walk and the result register.
// Depends on fssa_pkg; driven by fssa_ctrl commands.
module fssa_datapath
  import fssa_pkg::*;
#(
  parameter int SLOTS           = 256,
  parameter int PAGE_BYTES_LOG2 = 12,
  parameter int PAGE_ENTRIES    = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fssa_cmd_t           cmd,
  output fssa_sts_t           sts,
  input  logic [SIZE_W-1:0]   slot_size_log2,
  input  logic [ADDR_W-1:0]   in_address,
  input  logic [PAGE_W-1:0]   in_offered_page,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ADDR_W-1:0]   out_slot_address,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_page_taken,
  output logic [CNT_W-1:0]    out_allocation_count
);

  localparam int SW   = $clog2(SLOTS);
  localparam int PW   = (PAGE_ENTRIES > 1) ? $clog2(PAGE_ENTRIES) : 1;
  localparam int CW   = $clog2(SLOTS + 1);
  localparam int CLRN = (SLOTS > PAGE_ENTRIES) ? SLOTS : PAGE_ENTRIES;
  localparam int CLRW = $clog2(CLRN);

  // Memories with registered read data.
  logic [SW-1:0]     stack_mem [SLOTS];
  logic              use_mem   [SLOTS];
  logic [PAGE_W-1:0] pt_mem    [PAGE_ENTRIES];
  logic [SW-1:0]     stack_q;
  logic              use_q;
  logic [PAGE_W-1:0] pt_q;

  logic [ADDR_W-1:0] address_r;
  logic [PAGE_W-1:0] offered_r;
  logic [SW-1:0]     slot_r;
  logic [PW-1:0]     pidx_r;
  logic              bad_r;
  fssa_status_t      code_r;
  logic [CW-1:0]     fc_r, in_use_r, low_r;
  logic [CLRW-1:0]   clr_r;
  logic [PW-1:0]     wk_r, cmpk_r;
  logic              pend_r;

  logic                out_valid_r;
  logic [ADDR_W-1:0]   out_addr_r;
  logic [STATUS_W-1:0] out_status_r;
  logic                out_taken_r;
  logic [CNT_W-1:0]    out_count_r;

  logic [4:0]    s_eff, d_sh;
  logic [31:0]   slot_mask;
  logic [CW-1:0] pos_cw;
  logic [SW-1:0] top_slot, top_pidx;
  logic          top_bad;
  logic          need, a_fail;
  logic [PAGE_W-1:0] a_page;
  logic [ADDR_W-1:0] a_addr;
  logic [31:0]   page_num, idx32;
  logic          hit, found, walk_done, misaligned;
  logic          f_ok;
  fssa_status_t  f_status;
  logic [PW-1:0] pt_raddr;
  logic          clr_use, clr_pt;

  // Effective slot size, clamped between the minimum and the page size.
  always_comb begin
    s_eff = {1'b0, slot_size_log2};
    if (s_eff < SIZE_LOG2_MIN) s_eff = SIZE_LOG2_MIN;
    if (s_eff > 5'(PAGE_BYTES_LOG2)) s_eff = 5'(PAGE_BYTES_LOG2);
    d_sh      = 5'(PAGE_BYTES_LOG2) - s_eff;
    slot_mask = (32'd1 << d_sh) - 32'd1;
  end

  // Top of the free stack; entries below the low-water mark were never
  // overwritten and still hold their reset order.
  assign pos_cw   = fc_r - CW'(1);
  assign top_slot = (pos_cw < low_r) ? SW'(CW'(SLOTS - 1) - pos_cw) : stack_q;
  assign top_pidx = top_slot >> d_sh;
  assign top_bad  = (fc_r == '0) || (32'(top_pidx) >= 32'(PAGE_ENTRIES));

  // Allocate evaluation once the page-table entry is read.
  assign need   = (pt_q == '0);
  assign a_fail = bad_r || (need && (offered_r == '0));
  assign a_page = need ? offered_r : pt_q;
  assign a_addr = (32'(a_page) << PAGE_BYTES_LOG2)
                + (32'(slot_r & SW'(slot_mask)) << s_eff);

  // Free checks and page-table walk compare.
  assign misaligned = (address_r & ((32'd1 << s_eff) - 32'd1)) != '0;
  assign page_num   = address_r >> PAGE_BYTES_LOG2;
  assign hit        = (pt_q != '0) && (32'(pt_q) == page_num);
  assign idx32      = (32'(cmpk_r) << d_sh)
                    | (32'(address_r[PAGE_BYTES_LOG2-1:0]) >> s_eff);
  assign found      = hit && (idx32 < 32'(SLOTS));
  assign walk_done  = pend_r && (hit || (32'(cmpk_r) == 32'(PAGE_ENTRIES - 1)));

  assign f_ok     = (code_r == ST_OK) && use_q;
  assign f_status = (code_r != ST_OK) ? code_r : (use_q ? ST_OK : ST_ALREADY_FREE);

  assign pt_raddr = cmd.walk_step ? wk_r : pidx_r;
  assign clr_use  = cmd.clr_step && (32'(clr_r) < 32'(SLOTS));
  assign clr_pt   = cmd.clr_step && (32'(clr_r) < 32'(PAGE_ENTRIES));

  // Status back to the controller.
  always_comb begin
    sts.clr_done   = (32'(clr_r) == 32'(CLRN - 1));
    sts.chk_fail   = misaligned || (in_use_r == '0);
    sts.walk_done  = walk_done;
    sts.walk_found = found;
    sts.out_free   = !out_valid_r || out_ready;
  end

  // Memory ports.
  always_ff @(posedge clk) begin
    stack_q <= stack_mem[SW'(pos_cw)];
    use_q   <= use_mem[slot_r];
    pt_q    <= pt_mem[pt_raddr];
    if (cmd.commit_free && f_ok && (fc_r < CW'(SLOTS))) stack_mem[SW'(fc_r)] <= slot_r;
    if (clr_use) begin
      use_mem[SW'(clr_r)] <= 1'b0;
    end else if (cmd.commit_alloc && !a_fail) begin
      use_mem[slot_r] <= 1'b1;
    end else if (cmd.commit_free && f_ok) begin
      use_mem[slot_r] <= 1'b0;
    end
    if (clr_pt) begin
      pt_mem[PW'(clr_r)] <= '0;
    end else if (cmd.commit_alloc && !a_fail && need) begin
      pt_mem[pidx_r] <= offered_r;
    end
  end

  // Item payload and per-item working registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      address_r <= in_address;
      offered_r <= in_offered_page;
    end
    if (cmd.top_latch) begin
      slot_r <= top_slot;
      pidx_r <= PW'(top_pidx);
      bad_r  <= top_bad;
    end
    if (cmd.chk_latch) begin
      code_r <= misaligned ? ST_MISALIGNED : ((in_use_r == '0) ? ST_NONE_ALLOC : ST_OK);
    end
    if (cmd.walk_start) begin
      wk_r <= '0;
    end else if (cmd.walk_step) begin
      wk_r   <= wk_r + PW'(1);
      cmpk_r <= wk_r;
    end
    if (cmd.walk_step && walk_done) begin
      code_r <= found ? ST_OK : ST_NOT_FOUND;
      slot_r <= SW'(idx32);
    end
    if (cmd.commit_alloc || cmd.commit_free) begin
      out_addr_r <= (cmd.commit_alloc && !a_fail) ? a_addr : '0;
      out_taken_r <= cmd.commit_alloc && !a_fail && need;
      if (cmd.commit_alloc) begin
        out_status_r <= a_fail ? ST_EMPTY : ST_OK;
        out_count_r  <= a_fail ? CNT_W'(in_use_r) : CNT_W'(in_use_r + CW'(1));
      end else begin
        out_status_r <= f_status;
        out_count_r  <= f_ok ? CNT_W'(in_use_r - CW'(1)) : CNT_W'(in_use_r);
      end
    end
  end

  // Control state: counters, clearing pass, walk pipeline and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r        <= CW'(SLOTS);
      in_use_r    <= '0;
      low_r       <= CW'(SLOTS);
      clr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_r <= clr_r + CLRW'(1);
      if (cmd.walk_start) begin
        pend_r <= 1'b0;
      end else if (cmd.walk_step) begin
        pend_r <= 1'b1;
      end
      if (cmd.commit_alloc && !a_fail) begin
        fc_r     <= pos_cw;
        in_use_r <= in_use_r + CW'(1);
        if (pos_cw < low_r) low_r <= pos_cw;
      end
      if (cmd.commit_free && f_ok) begin
        if (fc_r < CW'(SLOTS)) fc_r <= fc_r + CW'(1);
        in_use_r <= in_use_r - CW'(1);
      end
      if (cmd.commit_alloc || cmd.commit_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_slot_address     = out_addr_r;
  assign out_status           = out_status_r;
  assign out_page_taken       = out_taken_r;
  assign out_allocation_count = out_count_r;

endmodule

@@ rtl/core/fixed_size_slot_allocator.sv @@
// Fixed-size slot allocator top level: configuration register, channels,
// controller and datapath. Depends on fssa_pkg, fssa_if, fssa_ctrl, fssa_datapath.
//
// Usage: after reset the block runs a clearing pass over the in-use bits and
// the page table, during which no item is accepted (configuration writes
// still are). One item is processed at a time. An allocate reads the top of
// the free stack, then the page-table entry for that slot, before its result.
// A free that fails its alignment or count check goes straight to its
// result. Otherwise it takes the page-table walk, which reads one entry per
// cycle and stops at the first match, and a usable match then reads the
// slot's in-use bit before the result. A result is committed only once the
// output register is free. The block accepts the next item in the cycle
// after a result is committed. A finished result waits in an output
// register, and the next item is accepted while it waits.
module fixed_size_slot_allocator
  import fssa_pkg::*;
#(
  parameter int SLOTS           = 256,
  parameter int PAGE_BYTES_LOG2 = 12,
  parameter int PAGE_ENTRIES    = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  fssa_in_if.sink               in_ch,
  fssa_out_if.source            out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [SIZE_W-1:0] slot_size_log2_r;
  fssa_cmd_t         cmd;
  fssa_sts_t         sts;

  // Slot size register, written in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_size_log2_r <= SIZE_LOG2_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == ADDR_SLOT_SIZE_LOG2)) begin
      slot_size_log2_r <= cfg_pwdata[SIZE_W-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_SLOT_SIZE_LOG2) ? CFG_DATA_W'(slot_size_log2_r) : '0;

  fssa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_func  (in_ch.func),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fssa_datapath #(
    .SLOTS           (SLOTS),
    .PAGE_BYTES_LOG2 (PAGE_BYTES_LOG2),
    .PAGE_ENTRIES    (PAGE_ENTRIES)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .slot_size_log2       (slot_size_log2_r),
    .in_address           (in_ch.address),
    .in_offered_page      (in_ch.offered_page),
    .out_valid            (out_ch.valid),
    .out_ready            (out_ch.ready),
    .out_slot_address     (out_ch.slot_address),
    .out_status           (out_ch.status),
    .out_page_taken       (out_ch.page_taken),
    .out_allocation_count (out_ch.allocation_count)
  );

endmodule

@@ rtl/core/fssa_checker.sv @@
// Port-level checks for the slot allocator, bound to the top level.
// Depends on fssa_pkg for the status codes.
module fssa_checker
  import fssa_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [ADDR_W-1:0]   out_slot_address,
  input logic [STATUS_W-1:0] out_status,
  input logic                out_page_taken
);

  // A pending result stays offered until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // Reset starts the clearing pass, so no item is taken right after it.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("item taken during clearing pass");

  // Failed operations never carry an address or a taken page.
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_slot_address == '0) && !out_page_taken)
    else $error("failed operation reports an address or page");

  // A taken page only comes with a successful allocate.
  a_taken_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_page_taken |-> out_status == ST_OK)
    else $error("page taken on a failed operation");

endmodule

bind fixed_size_slot_allocator fssa_checker u_fssa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_slot_address (out_ch.slot_address),
  .out_status       (out_ch.status),
  .out_page_taken   (out_ch.page_taken)
);

@@ sim/fixed_size_slot_allocator_tb.sv @@
// Self-checking testbench for the fixed-size slot allocator.
// Drives allocate/free items and register writes, predicts each result and compares it.
// Depends on fssa_pkg, fssa_if and the fixed_size_slot_allocator RTL.
`timescale 1ns / 100ps

// Holds the expected allocator state and the queue of predicted results.
class slot_pool_scoreboard;
  typedef struct packed {
    logic [31:0] slot_address;
    logic [2:0]  status;
    logic        page_taken;
    logic [8:0]  allocation_count;
  } alloc_result_t;

  bit [3:0]     size_log2;
  bit [7:0]     free_slots[256];
  int unsigned  num_free;
  bit           in_use[256];
  bit [19:0]    backing_page[256];
  int unsigned  num_in_use;
  alloc_result_t pending[$];
  int unsigned  errors;
  int unsigned  results_seen;
  int unsigned  n_alloc_ok, n_free_ok, n_other;

  function void clear();
    size_log2 = fssa_pkg::SIZE_LOG2_RESET;
    for (int k = 0; k < 256; k++) begin
      free_slots[k] = 8'(255 - k);
      in_use[k] = 1'b0;
      backing_page[k] = '0;
    end
    num_free = 256;
    num_in_use = 0;
  endfunction

  // Works out the result of one accepted item and queues it.
  function void note_request(bit fn, bit [31:0] addr, bit [19:0] offer);
    alloc_result_t r;
    int unsigned s, d, slot, pidx, found_slot, in_page;
    bit found;
    s = size_log2 < 4 ? 4 : (size_log2 > 12 ? 12 : size_log2);
    d = 12 - s;
    r = '0;
    if (fn == 1'b0) begin
      if (num_free == 0) begin
        r.status = fssa_pkg::ST_EMPTY;
      end else begin
        slot = free_slots[num_free - 1];
        pidx = slot >> d;
        if (backing_page[pidx] == 0 && offer == 0) begin
          r.status = fssa_pkg::ST_EMPTY;
        end else begin
          if (backing_page[pidx] == 0) begin
            backing_page[pidx] = offer;
            r.page_taken = 1'b1;
          end
          num_free--;
          in_use[slot] = 1'b1;
          num_in_use++;
          r.slot_address = {backing_page[pidx], 12'b0}
                           + (32'(slot & ((1 << d) - 1)) << s);
        end
      end
    end else if ((addr & ((32'd1 << s) - 1)) != 0) begin
      r.status = fssa_pkg::ST_MISALIGNED;
    end else if (num_in_use == 0) begin
      r.status = fssa_pkg::ST_NONE_ALLOC;
    end else begin
      found = 1'b0;
      found_slot = 0;
      // The lowest matching backed entry decides the lookup.
      for (int k = 0; k < 256; k++) begin
        if (backing_page[k] != 0 && backing_page[k] == addr[31:12]) begin
          in_page = addr[11:0];
          if (((k << d) + (in_page >> s)) < 256) begin
            found_slot = (k << d) + (in_page >> s);
            found = 1'b1;
          end
          break;
        end
      end
      if (!found) begin
        r.status = fssa_pkg::ST_NOT_FOUND;
      end else if (!in_use[found_slot]) begin
        r.status = fssa_pkg::ST_ALREADY_FREE;
      end else begin
        in_use[found_slot] = 1'b0;
        if (num_free < 256) begin
          free_slots[num_free] = 8'(found_slot);
          num_free++;
        end
        num_in_use--;
      end
    end
    r.allocation_count = 9'(num_in_use);
    if (r.status == fssa_pkg::ST_OK) begin
      if (fn) n_free_ok++;
      else n_alloc_ok++;
    end else begin
      n_other++;
    end
    pending.push_back(r);
  endfunction

  // Compares one result with the oldest expectation.
  function void check_result(alloc_result_t got);
    alloc_result_t want;
    results_seen++;
    if (pending.size() == 0) begin
      report("unexpected result", 0, 0);
      return;
    end
    want = pending.pop_front();
    if (got.slot_address !== want.slot_address)
      report("slot_address", got.slot_address, want.slot_address);
    if (got.status !== want.status) report("status", got.status, want.status);
    if (got.page_taken !== want.page_taken)
      report("page_taken", got.page_taken, want.page_taken);
    if (got.allocation_count !== want.allocation_count)
      report("allocation_count", got.allocation_count, want.allocation_count);
  endfunction

  function void report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("MISMATCH result %0d %s: got 0x%0h expected 0x%0h",
             results_seen, what, got, want);
  endfunction
endclass

module fixed_size_slot_allocator_tb;
  import fssa_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  fssa_in_if  in_ch ();
  fssa_out_if out_ch ();

  fixed_size_slot_allocator DUT (
    .clk, .rst_n, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  always #10 clk = ~clk;

  slot_pool_scoreboard pool = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_off_cycles = 0;
  int unsigned quiet_cycles = 0;
  int unsigned items_sent = 0;
  bit [19:0] last_pages[$];

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = 1'b0;
    in_ch.address = '0;
    in_ch.offered_page = '0;
    out_ch.ready = 1'b0;
  end

  // Receiver: random stalls plus an optional long hold-off.
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checking and the watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      pool.check_result({out_ch.slot_address, out_ch.status, out_ch.page_taken,
                         out_ch.allocation_count});
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results pending", pool.pending.size());
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one item and holds it until the block takes it. The block is busy
  // in the cycle after an accept, so valid drops for that cycle.
  task automatic send_item(bit fn, bit [31:0] addr, bit [19:0] offer);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_ch.valid <= 1'b1;
    in_ch.func <= fn;
    in_ch.address <= addr;
    in_ch.offered_page <= offer;
    do @(posedge clk); while (!in_ch.ready);
    pool.note_request(fn, addr, offer);
    items_sent++;
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pool.pending.size() != 0) @(posedge clk);
    // Leave a quiet gap before the next phase.
    repeat (300) @(posedge clk);
  endtask

  task automatic write_size_log2(bit [3:0] val);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_SLOT_SIZE_LOG2;
    cfg_pwdata <= {$urandom_range(32'hFFFF) << 4} | val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    pool.size_log2 = val;
  endtask

  task automatic do_alloc();
    bit [19:0] pg;
    // Reuse a page number now and then to build duplicate table entries.
    if (last_pages.size() > 0 && $urandom_range(9) == 0)
      pg = last_pages[$urandom_range(last_pages.size() - 1)];
    else if ($urandom_range(30) == 0)
      pg = ($urandom_range(1)) ? 20'hFFFFF : 20'd0;
    else
      pg = 20'($urandom_range(20'hFFFFF, 1));
    last_pages.push_back(pg);
    send_item(1'b0, $urandom(), pg);
  endtask

  // Frees mostly live slots, sometimes nearby or broken addresses.
  task automatic do_free();
    int unsigned s, k;
    bit [31:0] addr;
    s = pool.size_log2 < 4 ? 4 : (pool.size_log2 > 12 ? 12 : pool.size_log2);
    k = $urandom_range(255);
    addr = {pool.backing_page[k >> (12 - s)],
            12'((k & ((1 << (12 - s)) - 1)) << s)};
    case ($urandom_range(9))
      0: addr = $urandom();
      1: addr = addr | 32'(1 << $urandom_range(s - 1));
      default: ;
    endcase
    send_item(1'b1, addr, 20'($urandom()));
  endtask

  task automatic random_phase(int n, int unsigned s_idle, int unsigned r_idle);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 55) do_alloc();
      else do_free();
    end
  endtask

  initial begin
    pool.clear();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items: freeing with nothing allocated, misaligned, extremes.
    send_item(1'b1, 32'h0, 20'h1);
    send_item(1'b1, 32'hFFFF_FFFF, 20'hFFFFF);
    send_item(1'b0, 32'h0, 20'h0);
    send_item(1'b0, 32'hFFFF_FFFF, 20'hFFFFF);
    send_item(1'b0, 32'h0, 20'h1);
    send_item(1'b1, 32'hFFFF_F000, 20'h0);
    send_item(1'b1, 32'hFFFF_F000, 20'h0);
    send_item(1'b1, 32'hFFFF_F008, 20'h0);
    send_item(1'b1, 32'h1234_5670, 20'h0);
    send_item(1'b1, 32'hFFFF_F010, 20'h0);
    send_item(1'b0, 32'h0, 20'hAAAAA);
    send_item(1'b0, 32'h0, 20'h55555);
    wait_drained();

    write_size_log2(4'd12);
    random_phase(150, 25, 62);
    wait_drained();
    write_size_log2(4'd15);
    random_phase(80, 62, 25);
    wait_drained();
    write_size_log2(4'd0);
    random_phase(80, 62, 25);
    wait_drained();

    // Long hold-off on the result side while items keep coming.
    hold_off_cycles = 400;
    random_phase(40, 0, 0);
    // Sender pauses until everything has come back.
    wait_drained();

    write_size_log2(4'd7);
    // Exhaust the pool to reach the empty case.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 300 && pool.num_free > 0; i++) do_alloc();
    send_item(1'b0, 32'h0, 20'h1);
    random_phase(100, 0, 0);
    wait_drained();

    $display("Covered %0d items over slot sizes 2^4..2^12 with long output stalls.",
             items_sent);
    $display("Good allocates %0d, good frees %0d, error results %0d.",
             pool.n_alloc_ok, pool.n_free_ok, pool.n_other);
    if (pool.errors == 0 && pool.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/core/fssa_pkg.sv
rtl/core/fssa_if.sv
rtl/core/fssa_ctrl.sv
rtl/core/fssa_datapath.sv
rtl/core/fixed_size_slot_allocator.sv
rtl/core/fssa_checker.sv
sim/fixed_size_slot_allocator_tb.sv
